[design/pfb_to_pfa_converter_assert.svh]
// Assertion macros used by the checker file of the converter.
`ifndef PFB_TO_PFA_CONVERTER_ASSERT_SVH
`define PFB_TO_PFA_CONVERTER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define PFB2A_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked through reset as well.
`define PFB2A_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pfb2a_pkg.sv]
// Types, constants and helper functions of the segmented font converter.
`timescale 1ns / 1ps
`default_nettype none

package pfb2a_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_CHAR     = 2'd0;
  localparam logic [1:0] STATUS_BAD_MARK = 2'd1;
  localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;
  localparam logic [1:0] STATUS_END      = 2'd3;

  // Stream constants.
  localparam logic [7:0] SEG_MARK  = 8'h80;
  localparam logic [7:0] SEG_TEXT  = 8'h01;
  localparam logic [7:0] SEG_BIN   = 8'h02;
  localparam logic [7:0] SEG_END   = 8'h03;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] HBPL_RESET = 8'd30;

  // Job queue between the parser and the character generator.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One unit of work for the character generator.
  typedef struct packed {
    logic       hex;      // expand data into two hex digits
    logic [7:0] data;
    logic [1:0] status;
    logic       line_lf;  // line feed after the digits (line full)
    logic       end_lf;   // line feed after the digits (segment end)
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // Lower-case hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h57 + {4'd0, nib};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/pfb2a_if.sv]
// Valid/ready channel interfaces of the converter.
`timescale 1ns / 1ps
`default_nettype none

// Input word: one stream byte and the restart flag.
interface pfb2a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;
  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink (input valid, input in_byte, input start_of_file, output ready);
endinterface

// Configuration word: hex bytes per output line.
interface pfb2a_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_bytes_per_line;
  modport source (output valid, output hex_bytes_per_line, input ready);
  modport sink (input valid, input hex_bytes_per_line, output ready);
endinterface

// Output word: one character with its status.
interface pfb2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] status;
  logic       last_of_run;
  modport source (output valid, output out_char, output status, output last_of_run,
                  input ready);
  modport sink (input valid, input out_char, input status, input last_of_run,
                output ready);
endinterface

`default_nettype wire

[design/pfb_to_pfa_converter.sv]
// Top level of the segmented binary font to text font converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts a segmented binary font stream, one byte per input word, into text
// characters, one per output word. The parser takes a byte every cycle while
// its four-entry job queue has room; marker and type bytes give no characters,
// length bytes only the line feed closing an empty binary segment, a text byte
// one, and a binary byte two hex digits plus up to two line feeds. The
// character generator behind the queue emits one output word per cycle unless
// the output stalls, so a binary byte takes two to four output words and a
// text byte one; that port sets the sustained rate. Errors and the end segment
// each give one word with a nonzero status and a zero character. The line
// length register may be written while the block is idle.
module pfb_to_pfa_converter #(
  parameter int LENGTH_WIDTH = 31
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pfb2a_in_if.sink    in_ch,
  pfb2a_cfg_if.sink   cfg,
  pfb2a_out_if.source out_ch
);

  pfb2a_pkg::push_t push;
  pfb2a_pkg::job_t  head;
  logic             q_full;
  logic             head_valid;
  logic             pop;

  // Parser.
  pfb2a_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .cfg   (cfg),
    .push  (push),
    .q_full(q_full)
  );

  // Job queue.
  pfb2a_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  // Character generator.
  pfb2a_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[design/pfb2a_queue.sv]
// Small job queue between the parser and the character generator.
`timescale 1ns / 1ps
`default_nettype none

module pfb2a_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pfb2a_pkg::push_t push,
  output logic                  full,
  input  wire logic             pop,
  output pfb2a_pkg::job_t       head,
  output logic                  head_valid
);

  pfb2a_pkg::job_t                    entries [pfb2a_pkg::QDEPTH];
  logic [pfb2a_pkg::QPTR_W-1:0]       wr_ptr;
  logic [pfb2a_pkg::QPTR_W-1:0]       rd_ptr;
  logic [pfb2a_pkg::QCNT_W-1:0]       count;
  logic                               do_push;
  logic                               do_pop;

  assign full       = (count == pfb2a_pkg::QCNT_W'(pfb2a_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/pfb2a_front.sv]
// Segment parser: takes stream bytes, tracks segments and queues output jobs.
`timescale 1ns / 1ps
`default_nettype none

module pfb2a_front #(
  parameter int LENGTH_WIDTH = 31
) (
  input  wire logic       clk,
  input  wire logic       rst,
  pfb2a_in_if.sink        in_ch,
  pfb2a_cfg_if.sink       cfg,
  output pfb2a_pkg::push_t push,
  input  wire logic       q_full
);

  localparam logic [2:0] PH_MARKER = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_LENGTH = 3'd2;
  localparam logic [2:0] PH_TEXT   = 3'd3;
  localparam logic [2:0] PH_HEX    = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  logic [2:0]              phase, phase_next;
  logic [1:0]              len_idx, len_idx_next;
  logic                    is_binary, is_binary_next;
  logic [23:0]             gather, gather_next;
  logic [LENGTH_WIDTH-1:0] remaining, remaining_next;
  logic [7:0]              line_pos, line_pos_next;
  logic [7:0]              hbpl;

  logic                    accept;
  logic [2:0]              eff_phase;
  logic [7:0]              b;
  logic [31:0]             full_len;
  logic                    len_over;
  logic [LENGTH_WIDTH-1:0] len_sat;
  logic [7:0]              line_inc;

  assign in_ch.ready = !q_full;
  assign cfg.ready   = 1'b1;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign eff_phase   = in_ch.start_of_file ? PH_MARKER : phase;

  // Length as it stands once the last length byte is in; a set bit 31 makes it zero.
  assign full_len = {b, gather};
  assign len_over = ((full_len[30:0] >> LENGTH_WIDTH) != 31'd0);
  assign len_sat  = full_len[31] ? '0 :
                    len_over     ? '1 : full_len[LENGTH_WIDTH-1:0];
  assign line_inc = line_pos + 8'd1;

  // Parser step for one accepted word.
  always_comb begin
    phase_next     = phase;
    len_idx_next   = len_idx;
    is_binary_next = is_binary;
    gather_next    = gather;
    remaining_next = remaining;
    line_pos_next  = line_pos;
    push           = '0;
    if (accept) begin
      phase_next = eff_phase;
      case (eff_phase)
        PH_MARKER: begin
          if (b != pfb2a_pkg::SEG_MARK) begin
            push.valid      = 1'b1;
            push.job.status = pfb2a_pkg::STATUS_BAD_MARK;
            phase_next      = PH_ERROR;
          end else begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (b == pfb2a_pkg::SEG_TEXT || b == pfb2a_pkg::SEG_BIN) begin
            is_binary_next = (b == pfb2a_pkg::SEG_BIN);
            len_idx_next   = 2'd0;
            gather_next    = '0;
            phase_next     = PH_LENGTH;
          end else if (b == pfb2a_pkg::SEG_END) begin
            push.valid      = 1'b1;
            push.job.status = pfb2a_pkg::STATUS_END;
            phase_next      = PH_DONE;
          end else begin
            push.valid      = 1'b1;
            push.job.status = pfb2a_pkg::STATUS_BAD_TYPE;
            phase_next      = PH_ERROR;
          end
        end
        PH_LENGTH: begin
          case (len_idx)
            2'd0: begin
              gather_next[7:0] = b;
              len_idx_next     = 2'd1;
            end
            2'd1: begin
              gather_next[15:8] = b;
              len_idx_next      = 2'd2;
            end
            2'd2: begin
              gather_next[23:16] = b;
              len_idx_next       = 2'd3;
            end
            default: begin
              len_idx_next   = 2'd0;
              line_pos_next  = 8'd0;
              remaining_next = len_sat;
              if (len_sat == '0) begin
                // An empty binary segment still closes with a line feed.
                if (is_binary) begin
                  push.valid    = 1'b1;
                  push.job.data = pfb2a_pkg::CHAR_LF;
                end
                phase_next = PH_MARKER;
              end else begin
                phase_next = is_binary ? PH_HEX : PH_TEXT;
              end
            end
          endcase
        end
        PH_TEXT: begin
          push.valid     = 1'b1;
          push.job.data  = (b == pfb2a_pkg::CHAR_CR) ? pfb2a_pkg::CHAR_LF : b;
          remaining_next = remaining - 1'b1;
          if (remaining == LENGTH_WIDTH'(1)) begin
            phase_next = PH_MARKER;
          end
        end
        PH_HEX: begin
          push.valid       = 1'b1;
          push.job.hex     = 1'b1;
          push.job.data    = b;
          push.job.line_lf = (line_inc == hbpl);
          push.job.end_lf  = (remaining == LENGTH_WIDTH'(1));
          line_pos_next    = (line_inc == hbpl) ? 8'd0 : line_inc;
          remaining_next   = remaining - 1'b1;
          if (remaining == LENGTH_WIDTH'(1)) begin
            phase_next = PH_MARKER;
          end
        end
        default: begin
          // Past the end segment or an error: the byte is dropped.
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_MARKER;
      len_idx   <= 2'd0;
      is_binary <= 1'b0;
      gather    <= '0;
      remaining <= '0;
      line_pos  <= 8'd0;
    end else begin
      phase     <= phase_next;
      len_idx   <= len_idx_next;
      is_binary <= is_binary_next;
      gather    <= gather_next;
      remaining <= remaining_next;
      line_pos  <= line_pos_next;
    end
  end

  // Line length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hbpl <= pfb2a_pkg::HBPL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      hbpl <= cfg.hex_bytes_per_line;
    end
  end

endmodule

`default_nettype wire

[design/pfb2a_back.sv]
// Character generator: expands queued jobs into one output word per cycle unless the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module pfb2a_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pfb2a_pkg::job_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  pfb2a_out_if.source          out_ch
);

  pfb2a_pkg::job_t cur;
  logic            cur_valid;
  logic [1:0]      step;
  logic            ovalid;
  logic [7:0]      ochar;
  logic [1:0]      ostatus;
  logic            olast;

  logic [1:0]      last_step;
  logic            is_last;
  logic [7:0]      ch;
  logic            load;

  // Last step of the current job: one character, or two digits plus any line feeds.
  assign last_step = cur.hex ? (2'd1 + {1'b0, cur.line_lf} + {1'b0, cur.end_lf}) : 2'd0;
  assign is_last   = (step == last_step);

  // Character for the current step.
  always_comb begin
    if (!cur.hex) begin
      ch = cur.data;
    end else begin
      case (step)
        2'd0:    ch = pfb2a_pkg::hex_digit(cur.data[7:4]);
        2'd1:    ch = pfb2a_pkg::hex_digit(cur.data[3:0]);
        default: ch = pfb2a_pkg::CHAR_LF;
      endcase
    end
  end

  assign load = cur_valid && (!ovalid || out_ch.ready);
  assign pop  = head_valid && (!cur_valid || (load && is_last));

  // Current job and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 2'd0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        step      <= 2'd0;
      end else if (load) begin
        if (is_last) begin
          cur_valid <= 1'b0;
          step      <= 2'd0;
        end else begin
          step <= step + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ochar   <= ch;
      ostatus <= cur.status;
      olast   <= is_last;
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.out_char    = ochar;
  assign out_ch.status      = ostatus;
  assign out_ch.last_of_run = olast;

endmodule

`default_nettype wire

[design/pfb2a_checker.sv]
// Port-level assertions for the converter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "pfb_to_pfa_converter_assert.svh"

module pfb2a_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic [1:0] out_status,
  input wire logic       out_last
);

  // A word held back by the sink keeps its contents.
  `PFB2A_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable({out_char, out_status, out_last}), "output word changed while stalled")

  // Error and end reports stand alone and carry no character.
  `PFB2A_ASSERT(a_status_alone, clk, rst, out_valid && out_status != pfb2a_pkg::STATUS_CHAR |-> out_last && out_char == 8'd0, "status word malformed")

  // Reset empties the output register.
  `PFB2A_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind pfb_to_pfa_converter pfb2a_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_status(out_ch.status),
  .out_last  (out_ch.last_of_run)
);

`default_nettype wire

[tb/sv/pfb_to_pfa_converter_tb.sv]
// Self-checking testbench of the segmented font stream converter.
`timescale 1ns / 1ps

module pfb_to_pfa_converter_tb;

  // Parser states of the behavioral model.
  typedef enum logic [2:0] {
    SEEK_MARK, SEEK_TYPE, GATHER_LEN, COPY_TEXT, DUMP_HEX, STREAM_DONE, STREAM_ERR
  } parse_phase_e;

  // One output word as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] st;
    logic       last;
  } char_word_t;

  // One stimulus row: input word plus an optional hand-written expectation.
  // With typed set, has_word says whether exactly one word (ch, st) or none is due.
  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       typed;
    logic       has_word;
    logic [7:0] ch;
    logic [1:0] st;
  } stim_row_t;

  localparam int NUM_INTRO = 28;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 100;
  localparam logic [127:0] HEX_CHARS = "0123456789abcdef";

  // Directed opening: errors, dropped bytes, text, binary and the end segment.
  localparam stim_row_t INTRO_ROWS [NUM_INTRO] = '{
    '{8'h00,               1'b1, 1'b1, 1'b1, 8'h00,   pfb2a_pkg::STATUS_BAD_MARK},
    '{8'hFF,               1'b0, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_MARK, 1'b1, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'hFF,               1'b0, 1'b1, 1'b1, 8'h00,   pfb2a_pkg::STATUS_BAD_TYPE},
    '{pfb2a_pkg::SEG_MARK, 1'b1, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_TEXT, 1'b0, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h02,               1'b0, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::CHAR_CR,  1'b0, 1'b1, 1'b1, pfb2a_pkg::CHAR_LF, pfb2a_pkg::STATUS_CHAR},
    '{8'hFF,               1'b0, 1'b1, 1'b1, 8'hFF,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_MARK, 1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_BIN,  1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h02,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h80,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_MARK, 1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_BIN,  1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h02,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h00,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'hA5,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{8'h0F,               1'b0, 1'b0, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_MARK, 1'b0, 1'b1, 1'b0, 8'h00,   pfb2a_pkg::STATUS_CHAR},
    '{pfb2a_pkg::SEG_END,  1'b0, 1'b1, 1'b1, 8'h00,   pfb2a_pkg::STATUS_END}
  };

  logic clk;
  logic rst;

  pfb2a_in_if  in_ch();
  pfb2a_cfg_if cfg();
  pfb2a_out_if out_ch();

  pfb_to_pfa_converter dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .cfg(cfg),
    .out_ch(out_ch)
  );

  // Model state and the words it still expects.
  parse_phase_e model_phase;
  logic [1:0]   model_len_idx;
  logic         model_binary;
  logic [31:0]  model_len_acc;
  logic [30:0]  model_left;
  logic [7:0]   model_col;
  logic [7:0]   model_line_len;
  char_word_t   step_chars[$];
  char_word_t   pending_chars[$];

  int mismatch_count = 0;
  int live_items = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void restart_model();
    model_phase = SEEK_MARK;
    model_len_idx = '0;
    model_binary = 1'b0;
    model_len_acc = '0;
    model_left = '0;
    model_col = '0;
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic [1:0] st);
    step_chars.push_back({ch, st, 1'b0});
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    return HEX_CHARS[8 * (15 - nib) +: 8];
  endfunction

  // Computes the words that one accepted stream byte produces into step_chars.
  function automatic void convert_byte(input logic [7:0] b, input logic sof);
    logic [31:0] acc;
    char_word_t  tail;
    step_chars.delete();
    if (sof) restart_model();
    case (model_phase)
      SEEK_MARK: begin
        if (b != pfb2a_pkg::SEG_MARK) begin
          emit(8'h00, pfb2a_pkg::STATUS_BAD_MARK);
          model_phase = STREAM_ERR;
        end else begin
          model_phase = SEEK_TYPE;
        end
      end
      SEEK_TYPE: begin
        if (b == pfb2a_pkg::SEG_TEXT || b == pfb2a_pkg::SEG_BIN) begin
          model_binary = (b == pfb2a_pkg::SEG_BIN);
          model_len_idx = '0;
          model_len_acc = '0;
          model_phase = GATHER_LEN;
        end else if (b == pfb2a_pkg::SEG_END) begin
          emit(8'h00, pfb2a_pkg::STATUS_END);
          model_phase = STREAM_DONE;
        end else begin
          emit(8'h00, pfb2a_pkg::STATUS_BAD_TYPE);
          model_phase = STREAM_ERR;
        end
      end
      GATHER_LEN: begin
        // Little-endian length; a set top bit makes the segment empty.
        acc = model_len_acc | ({24'd0, b} << (8 * model_len_idx));
        model_len_acc = acc;
        if (model_len_idx != 2'd3) begin
          model_len_idx = model_len_idx + 2'd1;
        end else begin
          model_len_idx = '0;
          model_left = acc[31] ? '0 : acc[30:0];
          model_col = '0;
          if (model_left == '0) begin
            if (model_binary) emit(pfb2a_pkg::CHAR_LF, pfb2a_pkg::STATUS_CHAR);
            model_phase = SEEK_MARK;
          end else begin
            model_phase = model_binary ? DUMP_HEX : COPY_TEXT;
          end
        end
      end
      COPY_TEXT: begin
        emit((b == pfb2a_pkg::CHAR_CR) ? pfb2a_pkg::CHAR_LF : b, pfb2a_pkg::STATUS_CHAR);
        model_left = model_left - 31'd1;
        if (model_left == '0) model_phase = SEEK_MARK;
      end
      DUMP_HEX: begin
        emit(nibble_char(b[7:4]), pfb2a_pkg::STATUS_CHAR);
        emit(nibble_char(b[3:0]), pfb2a_pkg::STATUS_CHAR);
        model_col = model_col + 8'd1;
        if (model_col == model_line_len) begin
          emit(pfb2a_pkg::CHAR_LF, pfb2a_pkg::STATUS_CHAR);
          model_col = '0;
        end
        model_left = model_left - 31'd1;
        if (model_left == '0) begin
          emit(pfb2a_pkg::CHAR_LF, pfb2a_pkg::STATUS_CHAR);
          model_phase = SEEK_MARK;
        end
      end
      default: ;
    endcase
    if (step_chars.size() > 0) begin
      tail = step_chars.pop_back();
      tail.last = 1'b1;
      step_chars.push_back(tail);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic stim_row_t plain(input logic [7:0] b, input logic sof);
    return '{b, sof, 1'b0, 1'b0, 8'h00, pfb2a_pkg::STATUS_CHAR};
  endfunction

  // Offers one input word, with random idle cycles ahead of it, and logs its
  // expected output at the edge where it is taken.
  task automatic send_byte(input stim_row_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= r.b;
    in_ch.start_of_file <= r.sof;
    do @(posedge clk); while (!in_ch.ready);
    if (r.sof || (model_phase != STREAM_DONE && model_phase != STREAM_ERR)) live_items++;
    convert_byte(r.b, r.sof);
    if (r.typed) begin
      if (r.has_word) pending_chars.push_back({r.ch, r.st, 1'b1});
    end else begin
      foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
    end
  endtask

  // Holds the input low until every expected word has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic set_line_length(input logic [7:0] v);
    cfg.valid <= 1'b1;
    cfg.hex_bytes_per_line <= v;
    do @(posedge clk); while (!cfg.ready);
    model_line_len = v;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random font file: mostly well formed, sometimes cut short or broken.
  task automatic send_font_file();
    int          nseg;
    int          len;
    int          pick;
    logic        binary;
    logic [7:0]  t;
    logic [31:0] len_word;
    // Leading noise with a random restart flag.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
    end
    nseg = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      binary = 1'($urandom_range(0, 1));
      if (binary) begin
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(250, 280) : $urandom_range(0, 24);
      end else begin
        len = $urandom_range(0, 12);
      end
      len_word = len;
      if ($urandom_range(0, 19) == 0) begin
        len_word = {1'b1, 31'($urandom())};
        len = 0;
      end
      send_byte(plain(pfb2a_pkg::SEG_MARK, s == 0));
      send_byte(plain(binary ? pfb2a_pkg::SEG_BIN : pfb2a_pkg::SEG_TEXT, 1'b0));
      // Broken file: stop partway through the length field.
      if ($urandom_range(0, 24) == 0) begin
        pick = $urandom_range(0, 3);
        for (int k = 0; k < pick; k++) send_byte(plain(len_word[8 * k +: 8], 1'b0));
        return;
      end
      for (int k = 0; k < 4; k++) send_byte(plain(len_word[8 * k +: 8], 1'b0));
      for (int k = 0; k < len; k++) begin
        if (!binary && $urandom_range(0, 7) == 0) begin
          send_byte(plain(pfb2a_pkg::CHAR_CR, 1'b0));
        end else begin
          send_byte(plain(8'($urandom_range(0, 255)), 1'b0));
        end
      end
    end
    // Close the file with an end segment, a bad type or a bad marker.
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      send_byte(plain(pfb2a_pkg::SEG_MARK, 1'b0));
      send_byte(plain(pfb2a_pkg::SEG_END, 1'b0));
    end else if (pick == 8) begin
      send_byte(plain(pfb2a_pkg::SEG_MARK, 1'b0));
      do t = 8'($urandom_range(0, 255));
      while (t inside {pfb2a_pkg::SEG_TEXT, pfb2a_pkg::SEG_BIN, pfb2a_pkg::SEG_END});
      send_byte(plain(t, 1'b0));
    end else begin
      do t = 8'($urandom_range(0, 255)); while (t == pfb2a_pkg::SEG_MARK);
      send_byte(plain(t, 1'b0));
    end
  endtask

  // Output side: check each taken word, then choose the next ready.
  initial begin
    char_word_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_chars.size() == 0) begin
          flag_mismatch("unexpected word", out_ch.out_char, 8'h00);
        end else begin
          want = pending_chars.pop_front();
          if (out_ch.out_char !== want.ch) flag_mismatch("out_char", out_ch.out_char, want.ch);
          if (out_ch.status !== want.st) begin
            flag_mismatch("status", {6'd0, out_ch.status}, {6'd0, want.st});
          end
          if (out_ch.last_of_run !== want.last) begin
            flag_mismatch("last_of_run", {7'd0, out_ch.last_of_run}, {7'd0, want.last});
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Stimulus: directed rows, then random phases with their own line length
  // and idle pattern.
  initial begin
    int src_plan [NUM_PHASES];
    int sink_plan [NUM_PHASES];
    logic [7:0] len_plan [NUM_PHASES];
    src_plan = '{0, 47, 0, 11, 0};
    sink_plan = '{0, 0, 47, 11, 0};
    len_plan = '{8'd1, 8'd255, 8'd7, 8'($urandom_range(2, 254)), pfb2a_pkg::HBPL_RESET};
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.start_of_file = 1'b0;
    cfg.valid = 1'b0;
    cfg.hex_bytes_per_line = 8'h00;
    restart_model();
    model_line_len = pfb2a_pkg::HBPL_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_INTRO; i++) send_byte(INTRO_ROWS[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      // Words that produce nothing may still be in flight.
      repeat (10) @(posedge clk);
      set_line_length(len_plan[p]);
      src_idle_pct = src_plan[p];
      sink_stall_pct = sink_plan[p];
      while (live_items < NUM_INTRO + PHASE_ITEMS * (p + 1)) begin
        send_font_file();
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
